// ===== design/frbt_pkg.sv =====
`timescale 1ns / 1ps

package frbt_pkg;

  localparam int QueueDepth = 8;
  localparam int FrameBytes = 64;

  localparam int SlotW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int LenW  = $clog2(FrameBytes + 1);
  localparam int PosW  = (FrameBytes > 1) ? $clog2(FrameBytes) : 1;
  localparam int StoreDepth = QueueDepth * FrameBytes;
  localparam int AddrW = (StoreDepth > 1) ? $clog2(StoreDepth) : 1;

  typedef enum logic [1:0] {
    FUNC_APPEND  = 2'd0,
    FUNC_KICK    = 2'd1,
    FUNC_TX_DONE = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_FULL = 2'd1,
    STATUS_LONG = 2'd2
  } status_e;

  // Frame store access for one request
  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [7:0]       wdata;
    logic             re;
    logic [AddrW-1:0] raddr;
  } ram_req_t;

  // Result fields known at accept time; the byte follows from the store
  typedef struct packed {
    logic    tx_valid;
    status_e status;
    logic    busy;
  } meta_t;

endpackage

// ===== design/frbt_ram.sv =====
`timescale 1ns / 1ps

module frbt_ram #(
  parameter int Width = 8,
  parameter int Depth = 512,
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/frbt_ctrl.sv =====
`timescale 1ns / 1ps

module frbt_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [1:0]          func_i,
  input  logic [7:0]          data_byte_i,
  input  logic                last_byte_i,
  output frbt_pkg::ram_req_t  ram_req_o,
  output frbt_pkg::meta_t     meta_o
);

  logic [frbt_pkg::LenW-1:0]  len_q [frbt_pkg::QueueDepth];
  logic [frbt_pkg::LenW-1:0]  len_d [frbt_pkg::QueueDepth];
  logic [frbt_pkg::SlotW-1:0] head_q, head_d, tail_q, tail_d;
  logic [frbt_pkg::LenW-1:0]  pos_q, pos_d, count_q, count_d;
  logic                       sending_q, sending_d, ovf_q, ovf_d;

  logic [frbt_pkg::SlotW-1:0] next_tail, next_head, rd_slot;
  logic [frbt_pkg::PosW-1:0]  rd_pos;
  logic [frbt_pkg::LenW-1:0]  head_len;

  function automatic logic [frbt_pkg::SlotW-1:0] next_slot(
    input logic [frbt_pkg::SlotW-1:0] s
  );
    if (s == frbt_pkg::SlotW'(frbt_pkg::QueueDepth - 1)) begin
      return '0;
    end
    return s + 1'b1;
  endfunction

  assign next_tail = next_slot(tail_q);
  assign next_head = next_slot(head_q);
  assign head_len  = len_q[head_q];

  always_comb begin
    len_d     = len_q;
    head_d    = head_q;
    tail_d    = tail_q;
    pos_d     = pos_q;
    count_d   = count_q;
    sending_d = sending_q;
    ovf_d     = ovf_q;
    rd_slot   = head_q;
    rd_pos    = pos_q[frbt_pkg::PosW-1:0];
    ram_req_o.we    = 1'b0;
    ram_req_o.waddr = frbt_pkg::AddrW'(tail_q * frbt_pkg::FrameBytes)
                    + frbt_pkg::AddrW'(count_q[frbt_pkg::PosW-1:0]);
    ram_req_o.wdata = data_byte_i;
    ram_req_o.re    = 1'b0;
    meta_o.tx_valid = 1'b0;
    meta_o.status   = frbt_pkg::STATUS_OK;

    case (func_i)
      frbt_pkg::FUNC_APPEND: begin
        if (count_q < frbt_pkg::LenW'(frbt_pkg::FrameBytes)) begin
          ram_req_o.we = 1'b1;
          count_d      = count_q + 1'b1;
        end else begin
          ovf_d = 1'b1;
        end
        if (last_byte_i) begin
          if (next_tail == head_q) begin
            meta_o.status = frbt_pkg::STATUS_FULL;
          end else if (ovf_d) begin
            meta_o.status = frbt_pkg::STATUS_LONG;
          end else begin
            len_d[tail_q]    = count_d;
            len_d[next_tail] = '0;
            tail_d           = next_tail;
          end
          count_d = '0;
          ovf_d   = 1'b0;
        end
      end
      frbt_pkg::FUNC_KICK: begin
        if (head_q != tail_q && !sending_q && pos_q < head_len) begin
          ram_req_o.re    = 1'b1;
          meta_o.tx_valid = 1'b1;
          pos_d           = pos_q + 1'b1;
          sending_d       = 1'b1;
        end
      end
      frbt_pkg::FUNC_TX_DONE: begin
        if (sending_q) begin
          if (pos_q < head_len) begin
            ram_req_o.re    = 1'b1;
            meta_o.tx_valid = 1'b1;
            pos_d           = pos_q + 1'b1;
          end else begin
            // pop the finished frame, then start the next one if any
            len_d[head_q] = '0;
            head_d        = next_head;
            pos_d         = '0;
            if (next_head != tail_q) begin
              rd_slot         = next_head;
              rd_pos          = '0;
              ram_req_o.re    = 1'b1;
              meta_o.tx_valid = 1'b1;
              pos_d           = frbt_pkg::LenW'(1);
            end else begin
              sending_d = 1'b0;
            end
          end
        end
      end
      default: begin
      end
    endcase

    ram_req_o.raddr = frbt_pkg::AddrW'(rd_slot * frbt_pkg::FrameBytes)
                    + frbt_pkg::AddrW'(rd_pos);
    ram_req_o.we = ram_req_o.we & step_i;
    ram_req_o.re = ram_req_o.re & step_i;
    meta_o.busy  = sending_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < frbt_pkg::QueueDepth; i++) begin
        len_q[i] <= '0;
      end
      head_q    <= '0;
      tail_q    <= '0;
      pos_q     <= '0;
      count_q   <= '0;
      sending_q <= 1'b0;
      ovf_q     <= 1'b0;
    end else if (step_i) begin
      len_q     <= len_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      pos_q     <= pos_d;
      count_q   <= count_d;
      sending_q <= sending_d;
      ovf_q     <= ovf_d;
    end
  end

endmodule

// ===== design/frame_ring_byte_transmitter_core.sv =====
`timescale 1ns / 1ps

// Frame ring feeding a byte transmitter. Each request (append, kick or
// transmit-complete) gives one result, valid in the cycle after it is taken,
// from the output register and the registered read port of the frame store;
// a new request is taken every cycle while the result side keeps up, so the
// sustained rate is one request per cycle. The store needs no clearing after
// reset: only bytes of committed frames are ever read.
module frame_ring_byte_transmitter_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] func_i,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       tx_valid_o,
  output logic [7:0] tx_byte_o,
  output logic [1:0] status_o,
  output logic       busy_res_o
);

  frbt_pkg::ram_req_t ram_req;
  frbt_pkg::meta_t    meta_d, meta_q;
  logic               out_valid_q;
  logic               step;
  logic [7:0]         rdata;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign step       = in_valid_i && in_ready_o;

  frbt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .func_i      (func_i),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .ram_req_o   (ram_req),
    .meta_o      (meta_d)
  );

  frbt_ram #(
    .Width (8),
    .Depth (frbt_pkg::StoreDepth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      meta_q      <= '0;
    end else begin
      if (step) begin
        out_valid_q <= 1'b1;
        meta_q      <= meta_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // store read data holds until the next read, which only a new request issues
  assign out_valid_o = out_valid_q;
  assign tx_valid_o  = meta_q.tx_valid;
  assign tx_byte_o   = meta_q.tx_valid ? rdata : 8'd0;
  assign status_o    = meta_q.status;
  assign busy_res_o  = meta_q.busy;

endmodule

// ===== design/frbt_checker.sv =====
`timescale 1ns / 1ps

module frbt_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       tx_valid_o,
  input logic [7:0] tx_byte_o,
  input logic [1:0] status_o,
  input logic       busy_res_o
);

  // a drop is only flagged on an append, which never sends a byte
  a_drop_no_tx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != frbt_pkg::STATUS_OK |-> !tx_valid_o)
    else $error("drop status with a byte sent");

  a_idle_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !tx_valid_o |-> tx_byte_o == 8'd0)
    else $error("byte not zero without tx_valid");

  // handing over a byte leaves the transmitter busy
  a_tx_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && tx_valid_o |-> busy_res_o)
    else $error("byte sent while idle");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(tx_byte_o)
      && $stable(tx_valid_o) && $stable(status_o) && $stable(busy_res_o))
    else $error("stalled result changed");

endmodule

bind frame_ring_byte_transmitter_core frbt_checker u_frbt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .tx_valid_o  (tx_valid_o),
  .tx_byte_o   (tx_byte_o),
  .status_o    (status_o),
  .busy_res_o  (busy_res_o)
);

// ===== verif/tb_frame_ring_byte_transmitter_core.sv =====
`timescale 1ns / 1ps

module tb_frame_ring_byte_transmitter_core;

  localparam logic [1:0] FuncUnused = 2'd3;
  localparam int StallLimit = 2000;
  localparam int HoldOffCycles = 300;

  typedef struct packed {
    logic              tx_valid;
    logic [7:0]        tx_byte;
    frbt_pkg::status_e status;
    logic              busy;
  } tx_res_t;

  typedef enum int {
    RDY_ALWAYS,
    RDY_RANDOM,
    RDY_PERIODIC
  } rdy_mode_e;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [1:0] func_i = '0;
  logic [7:0] data_byte_i = '0;
  logic       last_byte_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic       tx_valid_o;
  logic [7:0] tx_byte_o;
  logic [1:0] status_o;
  logic       busy_res_o;

  frame_ring_byte_transmitter_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .tx_valid_o  (tx_valid_o),
    .tx_byte_o   (tx_byte_o),
    .status_o    (status_o),
    .busy_res_o  (busy_res_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the frame ring
  logic [7:0]                 ring_store [frbt_pkg::StoreDepth];
  logic [frbt_pkg::LenW-1:0]  ring_len [frbt_pkg::QueueDepth] = '{default: '0};
  logic [frbt_pkg::SlotW-1:0] ring_head = '0;
  logic [frbt_pkg::SlotW-1:0] ring_tail = '0;
  logic [frbt_pkg::LenW-1:0]  ring_pos = '0;
  logic [frbt_pkg::LenW-1:0]  ring_build = '0;
  bit                         ring_sending = 1'b0;
  bit                         ring_ovf = 1'b0;

  tx_res_t tx_results_due [$];
  int      n_errors = 0;
  int      burst_left = 1;
  bit      req_changed_state;

  bit        hold_req = 1'b0;
  int        hold_left = 0;
  rdy_mode_e rdy_mode = RDY_ALWAYS;
  int        rdy_mode_left = 0;
  int        rdy_period = 2;
  int        rdy_phase = 0;

  function automatic logic [frbt_pkg::SlotW-1:0] next_slot(
    input logic [frbt_pkg::SlotW-1:0] s
  );
    return (int'(s) == frbt_pkg::QueueDepth - 1) ? '0 : s + 1'b1;
  endfunction

  // Apply one request to the shadow ring; return 1 unless the block ignores it
  function automatic bit advance_ring(input logic [1:0] f, input logic [7:0] d,
                                      input logic l, output tx_res_t r);
    bit eff;
    r = '0;
    r.status = frbt_pkg::STATUS_OK;
    eff = 1'b0;
    case (f)
      frbt_pkg::FUNC_APPEND: begin
        eff = 1'b1;
        if (ring_build < frbt_pkg::FrameBytes) begin
          ring_store[int'(ring_tail) * frbt_pkg::FrameBytes + int'(ring_build)] = d;
          ring_build++;
        end else begin
          ring_ovf = 1'b1;
        end
        if (l) begin
          // full check wins over too long
          if (next_slot(ring_tail) == ring_head) begin
            r.status = frbt_pkg::STATUS_FULL;
          end else if (ring_ovf) begin
            r.status = frbt_pkg::STATUS_LONG;
          end else begin
            ring_len[ring_tail] = ring_build;
            ring_tail = next_slot(ring_tail);
            ring_len[ring_tail] = '0;
          end
          ring_build = '0;
          ring_ovf = 1'b0;
        end
      end
      frbt_pkg::FUNC_KICK: begin
        if (ring_head != ring_tail && !ring_sending && ring_pos < ring_len[ring_head]) begin
          eff = 1'b1;
          r.tx_valid = 1'b1;
          r.tx_byte = ring_store[int'(ring_head) * frbt_pkg::FrameBytes + int'(ring_pos)];
          ring_pos++;
          ring_sending = 1'b1;
        end
      end
      frbt_pkg::FUNC_TX_DONE: begin
        if (ring_sending) begin
          eff = 1'b1;
          if (ring_pos < ring_len[ring_head]) begin
            r.tx_valid = 1'b1;
            r.tx_byte = ring_store[int'(ring_head) * frbt_pkg::FrameBytes + int'(ring_pos)];
            ring_pos++;
          end else begin
            // pop the finished frame, start the next one if any
            ring_len[ring_head] = '0;
            ring_head = next_slot(ring_head);
            ring_pos = '0;
            if (ring_head != ring_tail) begin
              r.tx_valid = 1'b1;
              r.tx_byte = ring_store[int'(ring_head) * frbt_pkg::FrameBytes];
              ring_pos = 1;
            end else begin
              ring_sending = 1'b0;
            end
          end
        end
      end
      default: ;
    endcase
    r.busy = ring_sending;
    return eff;
  endfunction

  task automatic send_req(input logic [1:0] f, input logic [7:0] d, input logic l);
    tx_res_t r;
    in_valid_i <= 1'b1;
    func_i <= f;
    data_byte_i <= d;
    last_byte_i <= l;
    do @(posedge clk_i); while (!in_ready_o);
    req_changed_state = advance_ring(f, d, l, r);
    tx_results_due.push_back(r);
    burst_left--;
    if (burst_left <= 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 12);
    end
  endtask

  task automatic send_frame(input int len);
    for (int i = 0; i < len; i++) begin
      send_req(frbt_pkg::FUNC_APPEND, 8'($urandom_range(0, 255)), i == len - 1);
    end
  endtask

  // Close any partial frame, then transmit until the ring is empty and idle
  task automatic flush_ring();
    if (ring_build != 0) send_req(frbt_pkg::FUNC_APPEND, 8'($urandom_range(0, 255)), 1'b1);
    while (ring_sending || ring_head != ring_tail) begin
      if (!ring_sending) send_req(frbt_pkg::FUNC_KICK, 8'($urandom_range(0, 255)), 1'($urandom));
      else send_req(frbt_pkg::FUNC_TX_DONE, 8'($urandom_range(0, 255)), 1'($urandom));
    end
  endtask

  // Mostly well-formed frames mixed with kicks and completions; n counts
  // only requests that the block acts on
  task automatic run_traffic(input int n);
    int done;
    int left;
    int r;
    int p;
    done = 0;
    left = 0;
    while (done < n) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        if (left == 0) begin
          p = $urandom_range(0, 99);
          if (p < 85) left = $urandom_range(1, 6);
          else if (p < 93) left = $urandom_range(7, 40);
          else if (p < 97) left = $urandom_range(60, frbt_pkg::FrameBytes);
          else left = $urandom_range(frbt_pkg::FrameBytes + 1, frbt_pkg::FrameBytes + 6);
        end
        send_req(frbt_pkg::FUNC_APPEND, 8'($urandom_range(0, 255)), left == 1);
        left--;
      end else if (r < 55) begin
        send_req(frbt_pkg::FUNC_KICK, 8'($urandom_range(0, 255)), 1'($urandom));
      end else if (r < 92) begin
        send_req(frbt_pkg::FUNC_TX_DONE, 8'($urandom_range(0, 255)), 1'($urandom));
      end else if (r < 96) begin
        send_req(FuncUnused, 8'($urandom_range(0, 255)), 1'($urandom));
      end else begin
        // cut the frame short
        send_req(frbt_pkg::FUNC_APPEND, 8'($urandom_range(0, 255)), 1'b1);
        left = 0;
      end
      if (req_changed_state) done++;
    end
  endtask

  task automatic test_idle_events();
    send_req(frbt_pkg::FUNC_KICK, 8'h00, 1'b0);
    send_req(frbt_pkg::FUNC_TX_DONE, 8'hFF, 1'b1);
    send_req(FuncUnused, 8'hFF, 1'b1);
  endtask

  task automatic test_short_frame();
    send_req(frbt_pkg::FUNC_APPEND, 8'h00, 1'b0);
    send_req(frbt_pkg::FUNC_APPEND, 8'hFF, 1'b1);
    send_req(frbt_pkg::FUNC_KICK, 8'h00, 1'b0);
    send_req(frbt_pkg::FUNC_KICK, 8'hFF, 1'b1);
    send_req(frbt_pkg::FUNC_TX_DONE, 8'h00, 1'b0);
    send_req(frbt_pkg::FUNC_TX_DONE, 8'h00, 1'b0);
    send_req(frbt_pkg::FUNC_TX_DONE, 8'hFF, 1'b1);
  endtask

  task automatic test_ring_full();
    flush_ring();
    for (int i = 0; i < frbt_pkg::QueueDepth - 1; i++) begin
      send_req(frbt_pkg::FUNC_APPEND, (i % 2) ? 8'hFF : 8'h00, 1'b1);
    end
    send_req(frbt_pkg::FUNC_APPEND, 8'h5A, 1'b1);
    flush_ring();
  endtask

  task automatic test_long_frames();
    flush_ring();
    send_frame(frbt_pkg::FrameBytes);
    send_frame(frbt_pkg::FrameBytes + 1);
    send_frame(frbt_pkg::FrameBytes + 36);
    send_frame(1);
    flush_ring();
    // full and too long at once
    for (int i = 0; i < frbt_pkg::QueueDepth - 1; i++) send_frame(1);
    send_frame(frbt_pkg::FrameBytes + 6);
    flush_ring();
  endtask

  task automatic test_random_traffic();
    run_traffic(600);
  endtask

  task automatic test_backpressure();
    burst_left = 400;
    hold_req = 1'b1;
    run_traffic(120);
  endtask

  // Receiver: own ready pattern, plus one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_left = HoldOffCycles;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      if (rdy_mode_left == 0) begin
        rdy_mode = rdy_mode_e'($urandom_range(0, 2));
        rdy_mode_left = $urandom_range(32, 256);
        rdy_period = $urandom_range(2, 7);
      end
      rdy_mode_left--;
      rdy_phase++;
      case (rdy_mode)
        RDY_ALWAYS: out_ready_i <= 1'b1;
        RDY_RANDOM: out_ready_i <= ($urandom_range(0, 3) != 0);
        default:    out_ready_i <= (rdy_phase % rdy_period) != 0;
      endcase
    end
  end

  always @(posedge clk_i) begin : check_results
    tx_res_t due;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (tx_results_due.size() == 0) begin
        $error("result with no request outstanding");
        n_errors++;
      end else begin
        due = tx_results_due.pop_front();
        if (tx_valid_o !== due.tx_valid) begin
          $error("tx_valid: expected %0d, got %0d", due.tx_valid, tx_valid_o);
          n_errors++;
        end
        if (tx_byte_o !== due.tx_byte) begin
          $error("tx_byte: expected %02h, got %02h", due.tx_byte, tx_byte_o);
          n_errors++;
        end
        if (status_o !== due.status) begin
          $error("status: expected %0d, got %0d", due.status, status_o);
          n_errors++;
        end
        if (busy_res_o !== due.busy) begin
          $error("busy_res: expected %0d, got %0d", due.busy, busy_res_o);
          n_errors++;
        end
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < StallLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle = 0;
      else idle++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_idle_events();
    test_short_frame();
    test_ring_full();
    test_long_frames();
    test_random_traffic();
    test_backpressure();
    in_valid_i <= 1'b0;
    while (tx_results_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (n_errors == 0 && tx_results_due.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
